// ===== rtl/core/pfe_pkg.sv =====
// Package with constants, types and helpers for the postfix expression evaluator.
`default_nettype none
package pfe_pkg;
  localparam int STACK_DEPTH_DEF = 16;
  localparam int MAX_FRAC_DEF = 5;
  localparam logic [7:0] SEP_RESET = 8'd63;
  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_ADD = 8'h2B;
  localparam logic [7:0] CH_SUB = 8'h2D;
  localparam logic [7:0] CH_MUL = 8'h2A;
  localparam logic [7:0] CH_DIV = 8'h2F;
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [15:0] WHOLE_CAP = 16'd32768;

  function automatic logic [16:0] pow10(input logic [2:0] n);
    case (n)
      3'd0: pow10 = 17'd1;
      3'd1: pow10 = 17'd10;
      3'd2: pow10 = 17'd100;
      3'd3: pow10 = 17'd1000;
      3'd4: pow10 = 17'd10000;
      default: pow10 = 17'd100000;
    endcase
  endfunction

  function automatic logic signed [31:0] clamp(input logic signed [63:0] v,
                                               output logic sat);
    sat = 1'b0;
    if (v > 64'sh7FFFFFFF) begin
      sat = 1'b1;
      clamp = 32'sh7FFFFFFF;
    end else if (v < -64'sh80000000) begin
      sat = 1'b1;
      clamp = 32'sh80000000;
    end else begin
      clamp = v[31:0];
    end
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/postfix_expression_evaluator.sv =====
// Top level of the postfix expression evaluator with its stack RAM and control.
//  channel | direction | ports
//  in      | input     | in_valid, in_stall, in_char_code
//  out     | output    | out_valid, out_stall, out_answer_value, flags
//  cfg     | input     | cfg_we, cfg_wdata
// Digits, '.', other characters and short-stack operators stay in S_IDLE; a '=' pops in S_EQ.
// A push divides the fraction by its power of ten on the bit-serial divider.
// Operators: S_RDA, S_RDB, then S_MUL for * or S_DIV for a nonzero divisor, then S_EXE.
// A '=' result waits in the output register; only a following '=' is held until it is taken.
// Synchronous reset clears the stack level, the number, the pending flags and out_valid.
`default_nettype none
module postfix_expression_evaluator import pfe_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int MAX_FRACTION_DIGITS = MAX_FRAC_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_char_code,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [31:0] out_answer_value,
  output logic             out_stack_empty_error,
  output logic             out_stack_full_error,
  output logic             out_saturated,
  output logic             out_divided_by_zero,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata
);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int LW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001, S_PUSH = 9'b000000010, S_RDA  = 9'b000000100,
    S_RDB  = 9'b000001000, S_EXE  = 9'b000010000, S_DIV  = 9'b000100000,
    S_EQ   = 9'b001000000, S_MUL  = 9'b010000000, S_CONV = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [7:0] sep_r;
  logic [LW-1:0] lvl_r, lvl_nxt;
  logic [15:0] whole_r, whole_nxt;
  logic [16:0] frac_r, frac_nxt;
  logic [2:0] fcnt_r, fcnt_nxt;
  logic pt_r, pt_nxt, lastop_r, lastop_nxt;
  logic [3:0] err_r, err_nxt;
  logic [7:0] op_r, op_nxt;
  logic signed [31:0] a_r, a_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic ov_nxt;
  logic signed [31:0] ans_r, ans_nxt;
  logic [3:0] oflag_r, oflag_nxt;
  logic [16:0] fq_r, fq_nxt;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] wdata, rdata;
  logic dstart, ddone;
  logic signed [63:0] dq;
  logic signed [63:0] div_dividend;
  logic signed [31:0] div_divisor;

  pfe_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );
  pfe_divider u_div (
    .clk, .rst_n, .start(dstart), .dividend(div_dividend), .divisor(div_divisor),
    .done(ddone), .quotient(dq)
  );

  logic accept, is_op;
  logic [7:0] c;
  logic [34:0] fsum;
  logic [48:0] total;
  logic [16:0] scale;
  logic [20:0] wmul;
  logic sat;
  logic signed [31:0] res;
  logic [63:0] mag;

  assign c = in_char_code;
  assign in_stall = (state_r != S_IDLE) || (out_valid && c == CH_EQ);
  assign accept = in_valid && !in_stall;
  assign is_op = c == CH_ADD || c == CH_SUB || c == CH_MUL || c == CH_DIV;
  assign out_answer_value = ans_r;
  assign {out_divided_by_zero, out_saturated, out_stack_full_error,
          out_stack_empty_error} = oflag_r;

  always_comb begin
    state_nxt = state_r;
    lvl_nxt = lvl_r; whole_nxt = whole_r; frac_nxt = frac_r; fcnt_nxt = fcnt_r;
    pt_nxt = pt_r; lastop_nxt = lastop_r; err_nxt = err_r; op_nxt = op_r;
    a_nxt = a_r; prod_nxt = prod_r; ov_nxt = out_valid;
    ans_nxt = ans_r; oflag_nxt = oflag_r; fq_nxt = fq_r;
    we = 1'b0; waddr = lvl_r[AW-1:0]; wdata = '0; raddr = '0;
    dstart = 1'b0; sat = 1'b0; res = '0; mag = '0;
    scale = pow10(fcnt_r);
    fsum = {frac_r, 16'd0} + {19'd0, scale[16:1]};
    div_dividend = 64'($signed(rdata)) <<< 16;
    div_divisor = a_r;
    total = {17'd0, whole_r, 16'd0} + {32'd0, fq_r};
    wmul = {5'd0, whole_r} * 21'd10 + {17'd0, c[3:0]};
    if (out_valid && !out_stall) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          lastop_nxt = is_op;
          op_nxt = c;
          if (c == sep_r) begin
            if (!lastop_r) begin
              div_dividend = 64'(fsum);
              div_divisor = 32'(scale);
              dstart = 1'b1;
              state_nxt = S_CONV;
            end
          end else if (is_op) begin
            if (lvl_r < LW'(2)) err_nxt[0] = 1'b1;
            else begin
              raddr = AW'(lvl_r - LW'(1));
              state_nxt = S_RDA;
            end
          end else if (c == CH_EQ) begin
            if (lvl_r == '0) begin
              err_nxt[0] = 1'b1;
              ans_nxt = '0;
              oflag_nxt = err_nxt;
              err_nxt = '0;
              ov_nxt = 1'b1;
            end else begin
              raddr = AW'(lvl_r - LW'(1));
              state_nxt = S_EQ;
            end
          end else if (c == CH_DOT) begin
            pt_nxt = 1'b1;
          end else if (c >= CH_0 && c <= CH_9) begin
            if (!pt_r) whole_nxt = (wmul > 21'(WHOLE_CAP)) ? WHOLE_CAP : wmul[15:0];
            else if (fcnt_r < 3'(MAX_FRACTION_DIGITS)) begin
              frac_nxt = 17'({frac_r, 3'd0} + {2'd0, frac_r, 1'b0} + {16'd0, c[3:0]});
              fcnt_nxt = fcnt_r + 3'd1;
            end
          end
        end
      end
      S_CONV: begin
        if (ddone) begin
          fq_nxt = dq[16:0];
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (lvl_r >= LW'(STACK_DEPTH)) err_nxt[1] = 1'b1;
        else begin
          we = 1'b1;
          if (total > 49'h7FFFFFFF) begin
            wdata = 32'h7FFFFFFF;
            err_nxt[2] = 1'b1;
          end else wdata = total[31:0];
          lvl_nxt = lvl_r + LW'(1);
        end
        whole_nxt = '0; frac_nxt = '0; fcnt_nxt = '0; pt_nxt = 1'b0;
        state_nxt = S_IDLE;
      end
      S_EQ: begin
        ans_nxt = rdata;
        oflag_nxt = err_r;
        err_nxt = '0;
        ov_nxt = 1'b1;
        lvl_nxt = lvl_r - LW'(1);
        state_nxt = S_IDLE;
      end
      S_RDA: begin
        a_nxt = rdata;
        raddr = AW'(lvl_r - LW'(2));
        state_nxt = S_RDB;
      end
      S_RDB: begin
        case (op_r)
          CH_ADD: prod_nxt = 64'($signed(rdata)) + 64'(a_r);
          CH_SUB: prod_nxt = 64'($signed(rdata)) - 64'(a_r);
          CH_MUL: prod_nxt = $signed(rdata) * a_r;
          default: prod_nxt = 64'($signed(rdata)) <<< 16;
        endcase
        state_nxt = (op_r == CH_DIV) ? S_DIV : (op_r == CH_MUL) ? S_MUL : S_EXE;
        if (op_r == CH_DIV && a_r == '0) state_nxt = S_EXE;
      end
      S_MUL: begin
        mag = prod_r[63] ? 64'(-prod_r) : prod_r;
        mag = (mag + 64'd32768) >> 16;
        prod_nxt = prod_r[63] ? -$signed(mag) : $signed(mag);
        state_nxt = S_EXE;
      end
      S_DIV: begin
        if (ddone) begin
          prod_nxt = dq;
          op_nxt = CH_ADD;
          state_nxt = S_EXE;
        end
      end
      S_EXE: begin
        if (op_r == CH_DIV) begin
          err_nxt[3] = 1'b1;
          res = prod_r[63] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end else begin
          res = clamp(prod_r, sat);
          if (sat) err_nxt[2] = 1'b1;
        end
        we = 1'b1;
        waddr = AW'(lvl_r - LW'(2));
        wdata = res;
        lvl_nxt = lvl_r - LW'(1);
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_RDB && op_r == CH_DIV && a_r != '0) dstart = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sep_r <= SEP_RESET;
      lvl_r <= '0;
      whole_r <= '0; frac_r <= '0; fcnt_r <= '0; pt_r <= 1'b0;
      lastop_r <= 1'b0; err_r <= '0; out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) sep_r <= cfg_wdata;
      lvl_r <= lvl_nxt;
      whole_r <= whole_nxt; frac_r <= frac_nxt; fcnt_r <= fcnt_nxt; pt_r <= pt_nxt;
      lastop_r <= lastop_nxt; err_r <= err_nxt; out_valid <= ov_nxt;
    end
    op_r <= op_nxt; a_r <= a_nxt; prod_r <= prod_nxt;
    ans_r <= ans_nxt; oflag_r <= oflag_nxt; fq_r <= fq_nxt;
  end
endmodule
`default_nettype wire

// ===== rtl/core/pfe_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module pfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/pfe_divider.sv =====
// Iterative signed restoring divider, one quotient bit per cycle.
`default_nettype none
module pfe_divider (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [63:0] dividend,
  input  wire logic signed [31:0] divisor,
  output logic                    done,
  output logic signed [63:0]      quotient
);
  logic [63:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dv_r, dv_nxt;
  logic        neg_r, neg_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [32:0] trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    dv_nxt = dv_r;
    neg_nxt = neg_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done = 1'b0;
    trial = {rem_r[31:0], q_r[63]} - {1'b0, dv_r};
    if (start) begin
      q_nxt = dividend[63] ? 64'(-dividend) : dividend;
      dv_nxt = divisor[31] ? 32'(-divisor) : divisor;
      neg_nxt = dividend[63] ^ divisor[31];
      rem_nxt = '0;
      cnt_nxt = 7'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r == 7'd64) begin
        busy_nxt = 1'b0;
        done = 1'b1;
      end else begin
        if (!trial[32]) begin
          rem_nxt = trial;
          q_nxt = {q_r[62:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[31:0], q_r[63]};
          q_nxt = {q_r[62:0], 1'b0};
        end
        cnt_nxt = cnt_r + 7'd1;
      end
    end
  end

  assign quotient = neg_r ? -$signed(q_r) : $signed(q_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    dv_r <= dv_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
  end
endmodule
`default_nettype wire

// ===== test/tb_postfix_expression_evaluator.sv =====
// Testbench for the postfix expression evaluator: directed and random character streams.
`timescale 1ns / 1ps
module tb_postfix_expression_evaluator;
  import pfe_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [7:0] in_char_code;
  logic out_valid;
  logic out_stall;
  logic signed [31:0] out_answer_value;
  logic out_stack_empty_error;
  logic out_stack_full_error;
  logic out_saturated;
  logic out_divided_by_zero;
  logic cfg_we;
  logic [7:0] cfg_wdata;

  typedef struct packed {
    logic [31:0] answer;
    logic empty_err;
    logic full_err;
    logic sat;
    logic div0;
  } answer_t;

  localparam int DEPTH = 16;
  localparam int MAX_FRAC = 5;
  localparam int LIMIT_CYCLES = 2000000;

  logic [7:0] sep_model;
  logic signed [31:0] stack_model [DEPTH];
  int unsigned level_model;
  logic [31:0] whole_model;
  logic [31:0] frac_model;
  int unsigned frac_digits_model;
  bit point_model;
  logic [3:0] err_model;
  bit prev_op_model;

  answer_t answers_due [$];
  int unsigned errors;
  int unsigned answers_seen;
  int unsigned requests_sent;
  int unsigned cycle_count;
  bit stall_mode;

  postfix_expression_evaluator dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_char_code(in_char_code),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_answer_value(out_answer_value),
    .out_stack_empty_error(out_stack_empty_error),
    .out_stack_full_error(out_stack_full_error),
    .out_saturated(out_saturated),
    .out_divided_by_zero(out_divided_by_zero),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [31:0] clamp_q16(input logic signed [63:0] v);
    if (v > 64'sh7FFFFFFF) begin
      err_model[2] = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (v < -64'sh80000000) begin
      err_model[2] = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic void clear_number();
    whole_model = '0;
    frac_model = '0;
    frac_digits_model = 0;
    point_model = 1'b0;
  endfunction

  function automatic void push_number();
    logic [63:0] scale;
    logic [63:0] frac;
    logic [63:0] total;
    if (level_model >= DEPTH) begin
      err_model[1] = 1'b1;
      clear_number();
      return;
    end
    scale = 64'd1;
    for (int i = 0; i < frac_digits_model; i++) scale = scale * 10;
    frac = (64'(frac_model) * 65536 + scale / 2) / scale;
    total = 64'(whole_model) * 65536 + frac;
    if (total > 64'h7FFFFFFF) begin
      total = 64'h7FFFFFFF;
      err_model[2] = 1'b1;
    end
    stack_model[level_model] = total[31:0];
    level_model++;
    clear_number();
  endfunction

  function automatic logic signed [31:0] combine(input logic [7:0] op,
                                                 input logic signed [31:0] b,
                                                 input logic signed [31:0] a);
    logic signed [63:0] p;
    logic [63:0] mag;
    if (op == CH_ADD) return clamp_q16(64'(b) + 64'(a));
    if (op == CH_SUB) return clamp_q16(64'(b) - 64'(a));
    if (op == CH_MUL) begin
      p = 64'(b) * 64'(a);
      mag = p < 0 ? -p : p;
      mag = (mag + 32768) >> 16;
      return clamp_q16(p < 0 ? -$signed(mag) : $signed(mag));
    end
    if (a == 0) begin
      err_model[3] = 1'b1;
      return b >= 0 ? 32'sh7FFFFFFF : 32'sh80000000;
    end
    return clamp_q16((64'(b) * 65536) / 64'(a));
  endfunction

  function automatic void evaluate_char(input logic [7:0] c);
    bit was_op;
    bit is_op;
    answer_t res;
    was_op = prev_op_model;
    is_op = c == CH_ADD || c == CH_SUB || c == CH_MUL || c == CH_DIV;
    prev_op_model = is_op;
    if (c == sep_model) begin
      if (!was_op) push_number();
    end else if (is_op) begin
      if (level_model < 2) begin
        err_model[0] = 1'b1;
      end else begin
        stack_model[level_model - 2] = combine(c, stack_model[level_model - 2],
                                               stack_model[level_model - 1]);
        level_model--;
      end
    end else if (c == CH_EQ) begin
      res.answer = '0;
      if (level_model == 0) begin
        err_model[0] = 1'b1;
      end else begin
        level_model--;
        res.answer = stack_model[level_model];
      end
      res.empty_err = err_model[0];
      res.full_err = err_model[1];
      res.sat = err_model[2];
      res.div0 = err_model[3];
      err_model = '0;
      answers_due.push_back(res);
    end else if (c == CH_DOT) begin
      point_model = 1'b1;
    end else if (c >= CH_0 && c <= CH_9) begin
      if (!point_model) begin
        whole_model = whole_model * 10 + (c - CH_0);
        if (whole_model > WHOLE_CAP) whole_model = WHOLE_CAP;
      end else if (frac_digits_model < MAX_FRAC) begin
        frac_model = frac_model * 10 + (c - CH_0);
        frac_digits_model++;
      end
    end
  endfunction

  task automatic send_char(input logic [7:0] c);
    in_valid <= 1'b1;
    in_char_code <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    evaluate_char(c);
    requests_sent++;
    if ($urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (answers_due.size() != 0 && cycle_count < LIMIT_CYCLES) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic set_separator(input logic [7:0] s);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_we <= 1'b0;
    sep_model = s;
    @(posedge clk);
  endtask

  task automatic send_number(input logic [7:0] sep);
    int unsigned wd;
    int unsigned fd;
    wd = $urandom_range(0, 7) == 0 ? $urandom_range(0, 7) : $urandom_range(0, 3);
    fd = $urandom_range(0, 7) == 0 ? $urandom_range(0, 7) : $urandom_range(0, 2);
    for (int i = 0; i < wd; i++) send_char(8'(CH_0 + $urandom_range(0, 9)));
    if (fd != 0 || $urandom_range(0, 5) == 0) begin
      send_char(CH_DOT);
      for (int i = 0; i < fd; i++) send_char(8'(CH_0 + $urandom_range(0, 9)));
    end
    send_char(sep);
  endtask

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 3))
      0: return CH_ADD;
      1: return CH_SUB;
      2: return CH_MUL;
      default: return CH_DIV;
    endcase
  endfunction

  task automatic test_directed();
    send_text("12.5?3?+=");
    send_text("7?2.25?-=");
    send_text("1.5?2.5?*=");
    send_text("9?0.5?/=");
    send_text("5??/=");
    send_text("=");
    send_text("+");
    send_text("99999.1234567?=");
    send_text("32767?32767?*=");
    send_text("1..5?=");
    send_text("3?+?=");
    send_char(8'h00);
    send_char(8'hFF);
  endtask

  task automatic test_full_stack();
    for (int i = 0; i < DEPTH + 2; i++) send_text("1?");
    for (int i = 0; i < DEPTH + 1; i++) send_char(CH_EQ);
  endtask

  task automatic test_random(input int unsigned count);
    int unsigned start;
    int unsigned depth;
    start = requests_sent;
    while (requests_sent - start < count && cycle_count < LIMIT_CYCLES) begin
      if ($urandom_range(0, 9) < 8) begin
        depth = 0;
        repeat ($urandom_range(1, 5)) begin
          send_number(sep_model);
          depth++;
          if (depth >= 2 && $urandom_range(0, 1) == 1) begin
            if ($urandom_range(0, 2) == 0) send_char(8'(-$signed(8'd1)) ^ 8'h00);
            send_char(pick_op());
            depth--;
          end
        end
        while (depth > 1) begin
          send_char(pick_op());
          depth--;
        end
        send_char(CH_EQ);
      end else begin
        repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic test_pause();
    send_text("4?6?*=");
    drain();
    send_text("8?2?/=");
  endtask

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 199) == 0) stall_mode = ~stall_mode;
      out_stall <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b0;
    end
  end

  initial begin
    answer_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        answers_seen++;
        if (answers_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected answer %h", out_answer_value);
        end else begin
          want = answers_due.pop_front();
          if (out_answer_value !== want.answer || out_stack_empty_error !== want.empty_err
              || out_stack_full_error !== want.full_err || out_saturated !== want.sat
              || out_divided_by_zero !== want.div0) begin
            errors++;
            if (errors <= 10)
              $display("Mismatch: expected %h e%b f%b s%b d%b, got %h e%b f%b s%b d%b",
                       want.answer, want.empty_err, want.full_err, want.sat, want.div0,
                       out_answer_value, out_stack_empty_error, out_stack_full_error,
                       out_saturated, out_divided_by_zero);
          end
        end
      end
    end
  end

  initial begin
    errors = 0;
    answers_seen = 0;
    requests_sent = 0;
    stall_mode = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_char_code = 8'h00;
    cfg_we = 1'b0;
    cfg_wdata = 8'h00;
    sep_model = SEP_RESET;
    level_model = 0;
    clear_number();
    err_model = '0;
    prev_op_model = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_stack();
    test_pause();
    test_random(500);
    set_separator(8'h20);
    test_random(400);
    set_separator(8'h00);
    test_random(250);
    set_separator(8'hFF);
    test_random(250);
    set_separator(CH_ADD);
    send_text("3+4+-=");
    set_separator(SEP_RESET);
    test_random(100);
    drain();
    $display("Sent %0d characters and checked %0d answers over several separators.",
             requests_sent, answers_seen);
    if (errors == 0 && answers_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ===== postfix_expression_evaluator.f =====
rtl/core/pfe_pkg.sv
rtl/core/pfe_ram.sv
rtl/core/pfe_divider.sv
rtl/core/postfix_expression_evaluator.sv
test/tb_postfix_expression_evaluator.sv
